// ===== rtl/i2c_master_register_transfer_assert.svh =====
// assertion macros for the checker file
`ifndef I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH

// same-cycle implication under synchronous reset
`define CHK_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("same-cycle check failed");

// next-cycle implication under synchronous reset
`define CHK_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/i2cmrt_pkg.sv =====
// shared types and constants of the i2c register transfer sequencer
package i2cmrt_pkg;

   localparam int PAYLOAD_DEPTH = 32;
   localparam int ADDR_W  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int COUNT_W = $clog2(PAYLOAD_DEPTH + 1);

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_LOAD  = 2'd1,
      OP_EVENT = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      DONE_BUSY  = 2'd0,
      DONE_FAIL  = 2'd1,
      DONE_READ  = 2'd2,
      DONE_WRITE = 2'd3
   } done_type;

   // bus status codes
   localparam logic [7:0] BS_START      = 8'h08;
   localparam logic [7:0] BS_RESTART    = 8'h10;
   localparam logic [7:0] BS_WADDR_ACK  = 8'h18;
   localparam logic [7:0] BS_WDATA_ACK  = 8'h28;
   localparam logic [7:0] BS_RADDR_ACK  = 8'h40;
   localparam logic [7:0] BS_RDATA_ACK  = 8'h50;
   localparam logic [7:0] BS_RDATA_NACK = 8'h58;

   localparam logic [6:0] SLAVE_ADDRESS_RESET = 7'd104;

   // result fields known at accept time
   typedef struct packed {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       start_level;
      logic       stop_level;
      logic       ack_level;
      logic       bus_reset;
      done_type   status;
      logic       ram_send;
      logic       ram_read;
   } stage_type;

endpackage

// ===== rtl/i2cmrt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module i2cmrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2c_master_register_transfer.sv =====
// i2c master register transfer sequencer, top level
//
// requests enter on req_* (opcode in req_tuser); each request yields exactly
// one response on rsp_*. a begin request arms a transfer and raises START;
// load and read requests access the 32-byte payload store; bus event
// requests carry a status code and the received byte and are answered with
// the byte to send and the start, stop and ack levels, or a bus reset. the user
// must write the seven-bit slave address via csr_wen/csr_wdata only while the
// block idles; the block itself does not enforce this.
// the state update and the payload ram read happen at accept; the ram read
// data register and the middle stage result are merged into the output
// register when the middle stage moves on. one request per cycle is accepted
// while the response side does not stall; each request uses the single ram
// read port at most once.
//
// reset clears the sequencer state, the slave address returns to 0x68 and
// the pipeline empties; payload contents are undefined until written.
// when rsp_tready is low the output register holds its response and one
// more request can still be accepted into the middle stage before
// req_tready drops.
module i2c_master_register_transfer
   import i2cmrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // config
   input  logic                  csr_wen,
   input  logic [6:0]            csr_wdata,   // slave_address
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // opcode
   // direction, reg_pointer[8:1], length[14:9], index[19:15],
   // data_byte[27:20], bus_status[35:28], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // send_byte[7:0], send_valid, start_level, stop_level, ack_level,
   // bus_reset, status[14:13], read_byte[22:15], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // request fields
   opcode_type  op;
   logic        dir;
   logic [7:0]  ptr;
   logic [5:0]  len;
   logic [4:0]  idx;
   logic [7:0]  dat;
   logic [7:0]  code;

   assign op   = opcode_type'(req_tuser);
   assign dir  = req_tdata[0];
   assign ptr  = req_tdata[8:1];
   assign len  = req_tdata[14:9];
   assign idx  = req_tdata[19:15];
   assign dat  = req_tdata[27:20];
   assign code = req_tdata[35:28];

   // sequencer state
   logic [6:0]         slave_address_ff;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [COUNT_W-1:0] transfer_length_ff, transfer_length_in;
   logic               read_mode_ff, read_mode_in;
   logic [7:0]         pointer_byte_ff, pointer_byte_in;
   logic               start_bit_ff, start_bit_in;
   logic               stop_bit_ff, stop_bit_in;
   logic               ack_bit_ff, ack_bit_in;
   done_type           done_code_ff, done_code_in;

   // pipeline
   logic            s1_valid_ff;
   stage_type       s1_ff, s1_in;
   logic            out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic            accept;
   logic            s1_move;

   // ram ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic               idx_in_range;
   logic               count_below;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] len_sat;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   assign idx_in_range = 9'(idx) < 9'(PAYLOAD_DEPTH);
   assign count_below  = byte_count_ff < transfer_length_ff;
   assign count_inc    = byte_count_ff + COUNT_W'(1);
   assign len_sat      = (9'(len) > 9'(PAYLOAD_DEPTH)) ? COUNT_W'(PAYLOAD_DEPTH)
                                                        : COUNT_W'(len);

   // next state and accept-time result fields
   always_comb begin
      byte_count_in      = byte_count_ff;
      transfer_length_in = transfer_length_ff;
      read_mode_in       = read_mode_ff;
      pointer_byte_in    = pointer_byte_ff;
      start_bit_in       = start_bit_ff;
      stop_bit_in        = stop_bit_ff;
      ack_bit_in         = ack_bit_ff;
      done_code_in       = done_code_ff;
      s1_in              = '0;
      ram_wr_en          = 1'b0;
      ram_wr_addr        = ADDR_W'(idx);
      ram_rd_en          = 1'b0;
      ram_rd_addr        = ADDR_W'(idx);
      unique case (op)
         OP_BEGIN: begin
            read_mode_in       = dir;
            pointer_byte_in    = ptr;
            transfer_length_in = len_sat;
            byte_count_in      = '0;
            done_code_in       = DONE_BUSY;
            stop_bit_in        = 1'b0;
            start_bit_in       = 1'b1;
         end
         OP_LOAD: begin
            ram_wr_en = idx_in_range;
         end
         OP_READ: begin
            ram_rd_en       = idx_in_range;
            s1_in.ram_read  = idx_in_range;
         end
         OP_EVENT: begin
            unique case (code)
               BS_START, BS_RESTART: begin
                  s1_in.send_byte  = {slave_address_ff, read_mode_ff};
                  s1_in.send_valid = 1'b1;
                  start_bit_in     = 1'b0;
                  byte_count_in    = '0;
               end
               BS_WADDR_ACK: begin
                  s1_in.send_byte  = pointer_byte_ff;
                  s1_in.send_valid = 1'b1;
               end
               BS_WDATA_ACK: begin
                  if (count_below) begin
                     s1_in.send_valid = 1'b1;
                     s1_in.ram_send   = 1'b1;
                     ram_rd_en        = 1'b1;
                     ram_rd_addr      = ADDR_W'(byte_count_ff);
                     byte_count_in    = count_inc;
                  end else begin
                     stop_bit_in  = 1'b1;
                     done_code_in = DONE_WRITE;
                  end
               end
               BS_RADDR_ACK: begin
                  ack_bit_in = transfer_length_ff > COUNT_W'(1);
               end
               BS_RDATA_ACK: begin
                  if (count_below) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = ADDR_W'(byte_count_ff);
                     byte_count_in = count_inc;
                  end
                  ack_bit_in = ({1'b0, byte_count_in} + (COUNT_W + 1)'(1))
                               < {1'b0, transfer_length_ff};
               end
               BS_RDATA_NACK: begin
                  if (count_below) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = ADDR_W'(byte_count_ff);
                     byte_count_in = count_inc;
                  end
                  stop_bit_in  = 1'b1;
                  ack_bit_in   = 1'b1;
                  done_code_in = DONE_READ;
               end
               default: begin
                  // nack, lost arbitration or unknown code
                  s1_in.bus_reset = 1'b1;
                  start_bit_in    = 1'b0;
                  stop_bit_in     = 1'b0;
                  ack_bit_in      = 1'b0;
                  done_code_in    = DONE_FAIL;
               end
            endcase
         end
         default: begin
         end
      endcase
      s1_in.start_level = start_bit_in;
      s1_in.stop_level  = stop_bit_in;
      s1_in.ack_level   = ack_bit_in;
      s1_in.status      = done_code_in;
      ram_wr_en         = ram_wr_en && accept;
      ram_rd_en         = ram_rd_en && accept;
   end

   // payload store
   i2cmrt_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_payload (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (dat),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // slave address register
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RESET;
      end else if (csr_wen) begin
         slave_address_ff <= csr_wdata;
      end
   end

   // sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff      <= '0;
         transfer_length_ff <= '0;
         read_mode_ff       <= 1'b0;
         pointer_byte_ff    <= '0;
         start_bit_ff       <= 1'b0;
         stop_bit_ff        <= 1'b0;
         ack_bit_ff         <= 1'b1;
         done_code_ff       <= DONE_BUSY;
      end else if (accept) begin
         byte_count_ff      <= byte_count_in;
         transfer_length_ff <= transfer_length_in;
         read_mode_ff       <= read_mode_in;
         pointer_byte_ff    <= pointer_byte_in;
         start_bit_ff       <= start_bit_in;
         stop_bit_ff        <= stop_bit_in;
         ack_bit_ff         <= ack_bit_in;
         done_code_ff       <= done_code_in;
      end
   end

   // middle stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // middle stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register payload, merges ram read data
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= {
            1'b0,
            (s1_ff.ram_read ? ram_rd_data : 8'h00),
            s1_ff.status,
            s1_ff.bus_reset,
            s1_ff.ack_level,
            s1_ff.stop_level,
            s1_ff.start_level,
            s1_ff.send_valid,
            (s1_ff.ram_send ? ram_rd_data : s1_ff.send_byte)
         };
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/i2cmrt_checker.sv =====
// port-level checker for the i2c register transfer sequencer and its bind
`include "i2c_master_register_transfer_assert.svh"

module i2cmrt_checker
   import i2cmrt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic fail_seen;
   logic idle_send;
   logic read_seen;

   assign fail_seen = rsp_tvalid && rsp_tdata[12];
   assign idle_send = rsp_tvalid && !rsp_tdata[8];
   assign read_seen = rsp_tvalid && (rsp_tdata[22:15] != 8'h00);

   // a stalled response holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
             rsp_tvalid && $stable(rsp_tdata))

   // a bus reset drops all request levels and reports failure
   `CHK_SAME(a_fail_levels, clock, reset, fail_seen,
             rsp_tdata[11:9] == 3'b000 && rsp_tdata[14:13] == DONE_FAIL)

   // no send byte without send valid
   `CHK_SAME(a_send_zero, clock, reset, idle_send, rsp_tdata[7:0] == 8'h00)

   // a returned store byte comes from a read request, no bus activity
   `CHK_SAME(a_read_quiet, clock, reset, read_seen,
             !rsp_tdata[8] && !rsp_tdata[12])

endmodule

bind i2c_master_register_transfer i2cmrt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_top.sv =====
// testbench for the i2c master register transfer sequencer
`timescale 1ns / 1ps

module tb_top;
   import i2cmrt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PERCENT = 32;

   // one request as the sequencer sees it
   typedef struct {
      opcode_type op;
      logic       dir;
      logic [7:0] ptr;
      logic [5:0] len;
      logic [4:0] idx;
      logic [7:0] dat;
      logic [7:0] code;
   } bus_request;

   // one response, field by field
   typedef struct {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       start_level;
      logic       stop_level;
      logic       ack_level;
      logic       bus_reset;
      done_type   status;
      logic [7:0] read_byte;
   } sequencer_response;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [6:0]            csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // mirror of the sequencer state
   logic [6:0]  slave_addr_q;
   logic [7:0]  payload_q [PAYLOAD_DEPTH];
   logic [PAYLOAD_DEPTH-1:0] written_q;
   int          count_q;
   int          xfer_len_q;
   logic        rd_mode_q;
   logic [7:0]  pointer_q;
   logic        start_q;
   logic        stop_q;
   logic        ack_q;
   done_type    done_q;

   sequencer_response pending_responses [$];
   int  mismatch_count = 0;
   int  accepted_requests = 0;
   int  cycle_count = 0;
   bit  steady = 1'b0;

   i2c_master_register_transfer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic bit take_break();
      return !steady && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
               what, cycle_count, got, want);
      mismatch_count++;
   endtask

   function automatic void store_received_byte(logic [7:0] b);
      if (count_q < xfer_len_q) begin
         payload_q[count_q] = b;
         written_q[count_q] = 1'b1;
         count_q++;
      end
   endfunction

   // expected response of one accepted request, updates the mirror state
   function automatic sequencer_response predict_response(bus_request r);
      sequencer_response res;
      res.send_byte = '0;
      res.send_valid = 1'b0;
      res.bus_reset = 1'b0;
      res.read_byte = '0;
      case (r.op)
         OP_BEGIN: begin
            rd_mode_q = r.dir;
            pointer_q = r.ptr;
            xfer_len_q = (r.len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(r.len);
            count_q = 0;
            done_q = DONE_BUSY;
            stop_q = 1'b0;
            start_q = 1'b1;
         end
         OP_LOAD: begin
            payload_q[r.idx] = r.dat;
            written_q[r.idx] = 1'b1;
         end
         OP_READ: res.read_byte = payload_q[r.idx];
         default: begin
            case (r.code)
               BS_START, BS_RESTART: begin
                  res.send_byte = {slave_addr_q, rd_mode_q};
                  res.send_valid = 1'b1;
                  start_q = 1'b0;
                  count_q = 0;
               end
               BS_WADDR_ACK: begin
                  res.send_byte = pointer_q;
                  res.send_valid = 1'b1;
               end
               BS_WDATA_ACK: begin
                  if (count_q < xfer_len_q) begin
                     res.send_byte = payload_q[count_q];
                     res.send_valid = 1'b1;
                     count_q++;
                  end else begin
                     stop_q = 1'b1;
                     done_q = DONE_WRITE;
                  end
               end
               BS_RADDR_ACK: ack_q = (xfer_len_q > 1);
               BS_RDATA_ACK: begin
                  store_received_byte(r.dat);
                  ack_q = (count_q + 1 < xfer_len_q);
               end
               BS_RDATA_NACK: begin
                  store_received_byte(r.dat);
                  stop_q = 1'b1;
                  ack_q = 1'b1;
                  done_q = DONE_READ;
               end
               default: begin
                  // nack, lost arbitration or unknown code
                  res.bus_reset = 1'b1;
                  start_q = 1'b0;
                  stop_q = 1'b0;
                  ack_q = 1'b0;
                  done_q = DONE_FAIL;
               end
            endcase
         end
      endcase
      res.start_level = start_q;
      res.stop_level = stop_q;
      res.ack_level = ack_q;
      res.status = done_q;
      return res;
   endfunction

   // present one request and wait for its handshake
   task automatic drive_request(bus_request r);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= {4'b0, r.code, r.dat, r.idx, r.len, r.ptr, r.dir};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_responses.push_back(predict_response(r));
      accepted_requests++;
   endtask

   // send a request, first filling any store entry it would read unwritten
   task automatic send_request(bus_request r);
      bus_request fill;
      int hole;
      hole = -1;
      if (r.op == OP_READ && !written_q[r.idx])
         hole = r.idx;
      else if (r.op == OP_EVENT && r.code == BS_WDATA_ACK && count_q < xfer_len_q &&
               !written_q[count_q])
         hole = count_q;
      if (hole >= 0) begin
         fill = r;
         fill.op = OP_LOAD;
         fill.idx = hole[4:0];
         fill.dat = 8'($urandom);
         drive_request(fill);
      end
      drive_request(r);
   endtask

   function automatic bus_request random_request();
      bus_request r;
      r.op = opcode_type'($urandom_range(3));
      r.dir = 1'($urandom);
      r.ptr = 8'($urandom);
      r.len = 6'($urandom);
      r.idx = 5'($urandom);
      r.dat = 8'($urandom);
      r.code = 8'($urandom);
      return r;
   endfunction

   task automatic send_event(logic [7:0] code);
      bus_request r;
      r = random_request();
      r.op = OP_EVENT;
      r.code = code;
      send_request(r);
   endtask

   task automatic send_begin(logic dir, logic [7:0] ptr, logic [5:0] len);
      bus_request r;
      r = random_request();
      r.op = OP_BEGIN;
      r.dir = dir;
      r.ptr = ptr;
      r.len = len;
      send_request(r);
   endtask

   task automatic send_load(logic [4:0] idx, logic [7:0] dat);
      bus_request r;
      r = random_request();
      r.op = OP_LOAD;
      r.idx = idx;
      r.dat = dat;
      send_request(r);
   endtask

   task automatic send_read(logic [4:0] idx);
      bus_request r;
      r = random_request();
      r.op = OP_READ;
      r.idx = idx;
      send_request(r);
   endtask

   // drain all outstanding requests and let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_slave_address(logic [6:0] addr);
      wait_idle();
      csr_wen <= 1'b1;
      csr_wdata <= addr;
      @(posedge clock);
      csr_wen <= 1'b0;
      slave_addr_q = addr;
   endtask

   function automatic int random_length();
      if ($urandom_range(7) == 0)
         return $urandom_range(63);
      return $urandom_range(6);
   endfunction

   function automatic logic [7:0] fault_code();
      case ($urandom_range(5))
         0: return 8'h20;
         1: return 8'h30;
         2: return 8'h38;
         3: return 8'h48;
         4: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // one transfer on the bus, optionally cut short by a fault at step break_at
   task automatic run_transfer(logic dir, int len, int break_at);
      logic [7:0] codes [$];
      int n;
      int i;
      n = (len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : len;
      codes.push_back($urandom_range(1) ? BS_START : BS_RESTART);
      if (!dir) begin
         codes.push_back(BS_WADDR_ACK);
         for (i = 0; i <= n; i++) codes.push_back(BS_WDATA_ACK);
      end else begin
         codes.push_back(BS_RADDR_ACK);
         for (i = 1; i < n; i++) codes.push_back(BS_RDATA_ACK);
         codes.push_back(BS_RDATA_NACK);
      end
      // preload part of the payload; the rest is filled on demand
      if (!dir)
         for (i = 0; i < n; i++)
            if ($urandom_range(1)) send_load(i[4:0], 8'($urandom));
      send_begin(dir, 8'($urandom), len[5:0]);
      for (i = 0; i < codes.size(); i++) begin
         if (i == break_at) begin
            send_event(fault_code());
            return;
         end
         send_event(codes[i]);
      end
      // read back some of what came in
      if (dir && n > 0)
         repeat ($urandom_range(2)) send_read(5'($urandom_range(n - 1)));
   endtask

   // extremes, every operation and the named special cases
   task automatic test_directed_cases();
      send_event(BS_WDATA_ACK);          // event with no begin
      send_event(8'h00);
      send_event(8'hFF);
      send_load(5'd0, 8'h00);
      send_load(5'd31, 8'hFF);
      send_read(5'd31);
      send_read(5'd0);
      send_begin(1'b0, 8'hFF, 6'd2);
      send_event(BS_START);
      send_event(BS_WADDR_ACK);
      send_event(BS_WDATA_ACK);
      send_event(BS_WDATA_ACK);
      send_event(BS_WDATA_ACK);
      // zero-length read still takes one byte off the bus
      send_begin(1'b1, 8'h00, 6'd0);
      send_event(BS_RESTART);
      send_event(BS_RADDR_ACK);
      send_event(BS_RDATA_NACK);
      // length above the store saturates
      send_begin(1'b1, 8'h5A, 6'd63);
      send_event(BS_RADDR_ACK);
      send_event(BS_RDATA_ACK);
      send_event(8'h20);
      send_event(8'h30);
      send_event(8'h38);
      send_event(8'h48);
   endtask

   task automatic test_write_transfers(int target);
      set_slave_address(7'd0);
      while (accepted_requests < target) run_transfer(1'b0, random_length(), -1);
   endtask

   task automatic test_read_transfers(int target);
      set_slave_address(7'd127);
      while (accepted_requests < target) run_transfer(1'b1, random_length(), -1);
   endtask

   // well-formed transfers mixed with broken ones and loose requests
   task automatic test_mixed_traffic(int target);
      int next_config;
      int kind;
      next_config = accepted_requests + 120;
      steady = 1'b1;
      while (accepted_requests < target) begin
         if (steady && accepted_requests > target - 220) steady = 1'b0;
         if (accepted_requests >= next_config) begin
            case ($urandom_range(3))
               0: set_slave_address(7'd0);
               1: set_slave_address(7'd127);
               default: set_slave_address(7'($urandom));
            endcase
            next_config = accepted_requests + 120;
         end
         kind = $urandom_range(99);
         if (kind < 35)
            run_transfer(1'b0, random_length(), -1);
         else if (kind < 70)
            run_transfer(1'b1, random_length(), -1);
         else if (kind < 85)
            run_transfer(1'($urandom), random_length(), $urandom_range(5));
         else
            send_request(random_request());
      end
      steady = 1'b0;
   endtask

   // response side: random back-pressure and in-order compare
   always @(posedge clock) begin : response_check
      sequencer_response want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with none expected", rsp_tdata, 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[7:0] !== want.send_byte)
               report_mismatch("send_byte", rsp_tdata[7:0], want.send_byte);
            if (rsp_tdata[8] !== want.send_valid)
               report_mismatch("send_valid", rsp_tdata[8], want.send_valid);
            if (rsp_tdata[9] !== want.start_level)
               report_mismatch("start_level", rsp_tdata[9], want.start_level);
            if (rsp_tdata[10] !== want.stop_level)
               report_mismatch("stop_level", rsp_tdata[10], want.stop_level);
            if (rsp_tdata[11] !== want.ack_level)
               report_mismatch("ack_level", rsp_tdata[11], want.ack_level);
            if (rsp_tdata[12] !== want.bus_reset)
               report_mismatch("bus_reset", rsp_tdata[12], want.bus_reset);
            if (rsp_tdata[14:13] !== want.status)
               report_mismatch("status", rsp_tdata[14:13], want.status);
            if (rsp_tdata[22:15] !== want.read_byte)
               report_mismatch("read_byte", rsp_tdata[22:15], want.read_byte);
         end
      end
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   initial begin
      // mirror state after reset
      slave_addr_q = SLAVE_ADDRESS_RESET;
      written_q = '0;
      count_q = 0;
      xfer_len_q = 0;
      rd_mode_q = 1'b0;
      pointer_q = '0;
      start_q = 1'b0;
      stop_q = 1'b0;
      ack_q = 1'b1;
      done_q = DONE_BUSY;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_write_transfers(170);
      test_read_transfers(320);
      test_mixed_traffic(660);
      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/i2cmrt_pkg.sv
rtl/i2cmrt_ram.sv
rtl/i2c_master_register_transfer.sv
rtl/i2cmrt_checker.sv
tb/tb_top.sv
